### sv/plm_pkg.sv
// Shared types and constants for the polynomial multiplier.
`default_nettype none

package plm_pkg;

  localparam int COEF_W  = 32;
  localparam int IDX_W   = 5;
  localparam int LEN_W   = 6;
  localparam int PIDX_W  = 6;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEN_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_B = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_MUL  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              kind;
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] value;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } eng_state_t;

endpackage

`default_nettype wire

### sv/polynomial_multiplier.sv
// Top level of the schoolbook polynomial multiplier.
// Load transfer: queued, then popped by the idle sequencer into the store; no result.
// Compute: coefficient k issues its terms on the single shared MAC pipe (store read,
// product register, accumulator), emitted once the pipe drains and the output is free.
// Reset (rst_n low, synchronous): queue, sequencer and output empty, len_a = len_b = 1;
// coefficient stores are not cleared.
`default_nettype none

module polynomial_multiplier #(
  parameter int MAX_TERMS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [plm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [plm_pkg::LEN_W-1:0]        cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [plm_pkg::CMD_W-1:0]        in_command,
  input  wire logic [plm_pkg::IDX_W-1:0]        in_coef_index,
  input  wire logic [plm_pkg::COEF_W-1:0]       in_coef_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [plm_pkg::PIDX_W-1:0]            out_prod_index,
  output logic [plm_pkg::COEF_W-1:0]            out_prod_value,
  output logic                                  out_last
);

  import plm_pkg::*;

  logic [LEN_W-1:0] len_a_r, len_a_nxt;
  logic [LEN_W-1:0] len_b_r, len_b_nxt;
  logic             q_valid;
  logic             q_pop;
  op_t              q_op;

  always_comb begin
    len_a_nxt = len_a_r;
    len_b_nxt = len_b_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LEN_A: len_a_nxt = cfg_wdata;
        CFG_LEN_B: len_b_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r <= LEN_W'(1);
      len_b_r <= LEN_W'(1);
    end else begin
      len_a_r <= len_a_nxt;
      len_b_r <= len_b_nxt;
    end
  end

  plm_front #(.MAX_TERMS(MAX_TERMS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .q_pop         (q_pop)
  );

  plm_back #(.MAX_TERMS(MAX_TERMS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop),
    .len_a          (len_a_r),
    .len_b          (len_b_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prod_index (out_prod_index),
    .out_prod_value (out_prod_value),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

### sv/plm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module plm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/plm_front.sv
// Front end: accepts input transfers, drops no-op items, queues operations.
`default_nettype none

module plm_front #(
  parameter int MAX_TERMS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [plm_pkg::CMD_W-1:0]     in_command,
  input  wire logic [plm_pkg::IDX_W-1:0]     in_coef_index,
  input  wire logic [plm_pkg::COEF_W-1:0]    in_coef_value,
  output logic                               q_valid,
  output plm_pkg::op_t                       q_op,
  input  wire logic                          q_pop
);

  import plm_pkg::*;

  op_t              q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]    cnt_r, cnt_nxt;
  logic             keep;
  logic             push;
  op_t              op_in;

  always_comb begin
    op_in.kind  = cmd_t'(in_command);
    op_in.idx   = in_coef_index;
    op_in.value = in_coef_value;
    case (in_command)
      CMD_WR_A, CMD_WR_B: keep = ({1'b0, in_coef_index} < LEN_W'(MAX_TERMS));
      CMD_MUL:            keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign push     = in_valid & in_ready & keep;
  assign q_valid  = (cnt_r != '0);
  assign q_op     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

`default_nettype wire

### sv/plm_back.sv
// Back end: coefficient stores, multiply-accumulate sequencer, output register.
`default_nettype none

module plm_back #(
  parameter int MAX_TERMS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire plm_pkg::op_t                 q_op,
  output logic                              q_pop,
  input  wire logic [plm_pkg::LEN_W-1:0]    len_a,
  input  wire logic [plm_pkg::LEN_W-1:0]    len_b,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [plm_pkg::PIDX_W-1:0]        out_prod_index,
  output logic [plm_pkg::COEF_W-1:0]        out_prod_value,
  output logic                              out_last
);

  import plm_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);

  eng_state_t          state_r, state_nxt;
  logic [PIDX_W-1:0]   k_r, k_nxt, k_start;
  logic [AW-1:0]       i_r, i_nxt;
  logic [AW-1:0]       i_hi_r, i_hi_nxt;
  logic [LEN_W-1:0]    lo_w, hi_w;
  logic [LEN_W-1:0]    na, nb, total_m1, kmi;
  logic                start_k, issue, emit, slot_free, is_last;
  logic                we_a, we_b;
  logic                rd_v_r, mul_v_r;
  logic [COEF_W-1:0]   a_rd, b_rd;
  logic [COEF_W-1:0]   full_prod;
  logic [COEF_W-1:0]   prod_r;
  logic [COEF_W-1:0]   acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PIDX_W-1:0]   out_idx_r;
  logic [COEF_W-1:0]   out_val_r;
  logic                out_last_r;

  // clamp lengths into 1..MAX_TERMS
  always_comb begin
    if (len_a == '0)                   na = LEN_W'(1);
    else if (len_a > LEN_W'(MAX_TERMS)) na = LEN_W'(MAX_TERMS);
    else                               na = len_a;
    if (len_b == '0)                   nb = LEN_W'(1);
    else if (len_b > LEN_W'(MAX_TERMS)) nb = LEN_W'(MAX_TERMS);
    else                               nb = len_b;
    total_m1 = na + nb - LEN_W'(2);
  end

  // term range of the next coefficient
  always_comb begin
    k_start = (state_r == ST_IDLE) ? '0 : k_r + 1'b1;
    lo_w    = (k_start >= nb) ? k_start - nb + LEN_W'(1) : '0;
    hi_w    = (k_start < na) ? k_start : na - LEN_W'(1);
  end

  assign kmi       = k_r - LEN_W'(i_r);
  assign slot_free = !out_valid_r || out_ready;
  assign is_last   = (k_r == total_m1);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    i_hi_nxt  = i_hi_r;
    q_pop     = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    start_k   = 1'b0;
    issue     = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_op.kind)
            CMD_WR_A: we_a = 1'b1;
            CMD_WR_B: we_b = 1'b1;
            CMD_MUL: begin
              start_k   = 1'b1;
              k_nxt     = '0;
              state_nxt = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (i_r == i_hi_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mul_v_r && slot_free) begin
          emit = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            start_k   = 1'b1;
            k_nxt     = k_start;
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (start_k) begin
      i_nxt    = lo_w[AW-1:0];
      i_hi_nxt = hi_w[AW-1:0];
    end
  end

  plm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (q_op.idx[AW-1:0]),
    .wdata (q_op.value),
    .re    (issue),
    .raddr (i_r),
    .rdata (a_rd)
  );

  plm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (q_op.idx[AW-1:0]),
    .wdata (q_op.value),
    .re    (issue),
    .raddr (kmi[AW-1:0]),
    .rdata (b_rd)
  );

  assign full_prod = a_rd * b_rd;

  always_comb begin
    acc_nxt = acc_r;
    if (start_k)      acc_nxt = '0;
    else if (mul_v_r) acc_nxt = acc_r + prod_r;
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= issue;
      mul_v_r     <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    i_hi_r <= i_hi_nxt;
    acc_r  <= acc_nxt;
    if (rd_v_r) begin
      prod_r <= full_prod;
    end
    if (emit) begin
      out_idx_r  <= k_r;
      out_val_r  <= acc_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prod_index = out_idx_r;
  assign out_prod_value = out_val_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_rd_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r == ST_ISSUE))
    else $error("read data valid without an issue cycle");

  a_mul_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    mul_v_r |-> $past(rd_v_r))
    else $error("product valid without read data");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> ((i_r <= i_hi_r) && (LEN_W'(i_r) < na) && (kmi < nb)))
    else $error("term index outside operand lengths");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> (state_r == ST_IDLE))
    else $error("sequencer busy after final coefficient");
`endif

endmodule

`default_nettype wire

### verif/polynomial_multiplier_tb.sv
// Testbench for polynomial_multiplier: queued loads and computes checked against a convolution predictor.
`timescale 1ns / 1ps

module polynomial_multiplier_tb;
  import plm_pkg::*;

  localparam int MAX_TERMS = 32;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] val;
  } req_t;

  typedef struct packed {
    logic [PIDX_W-1:0] idx;
    logic [COEF_W-1:0] val;
    logic              last;
  } coef_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = '0;
  logic [IDX_W-1:0]     in_coef_index = '0;
  logic [COEF_W-1:0]    in_coef_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIDX_W-1:0]    out_prod_index;
  logic [COEF_W-1:0]    out_prod_value;
  logic                 out_last;

  polynomial_multiplier #(.MAX_TERMS(MAX_TERMS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_coef_index(in_coef_index), .in_coef_value(in_coef_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_prod_index(out_prod_index),
    .out_prod_value(out_prod_value), .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t  req_queue[$];
  coef_t coef_queue[$];

  // predictor state
  logic [COEF_W-1:0] shadow_a[MAX_TERMS];
  logic [COEF_W-1:0] shadow_b[MAX_TERMS];
  logic [LEN_W-1:0]  shadow_len_a = 6'd1;
  logic [LEN_W-1:0]  shadow_len_b = 6'd1;

  // generator state
  logic [MAX_TERMS-1:0] loaded_a = '0;
  logic [MAX_TERMS-1:0] loaded_b = '0;
  int   gen_len_a = 1;
  int   gen_len_b = 1;
  int   stim_items = 0;
  bit   no_stall = 1'b0;

  int   in_count = 0;
  int   in_issued = 0;
  int   out_count = 0;
  int   out_seen = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   err_count = 0;
  req_t  drv_item;
  coef_t exp_coef;

  function automatic int eff_len(logic [LEN_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_TERMS) return MAX_TERMS;
    return int'(n);
  endfunction

  function automatic int draw_wait();
    return no_stall ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic void push_product();
    int na;
    int nb;
    int total;
    logic [COEF_W-1:0] acc;
    coef_t c;
    na = eff_len(shadow_len_a);
    nb = eff_len(shadow_len_b);
    total = na + nb - 1;
    for (int k = 0; k < total; k++) begin
      acc = '0;
      for (int i = 0; i < na; i++) begin
        if (i <= k && k - i < nb) acc += shadow_a[i] * shadow_b[k - i];
      end
      c.idx = k[PIDX_W-1:0];
      c.val = acc;
      c.last = (k + 1 == total);
      coef_queue = {coef_queue, c};
    end
  endfunction

  // monitor: config and input transfers feed the predictor, result transfers are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_LEN_A) shadow_len_a = cfg_wdata;
        else shadow_len_b = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        in_count++;
        case (in_command)
          CMD_WR_A: shadow_a[in_coef_index] = in_coef_value;
          CMD_WR_B: shadow_b[in_coef_index] = in_coef_value;
          CMD_MUL:  push_product();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_count++;
        if (coef_queue.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: idx %0d value %h last %b",
                     out_prod_index, out_prod_value, out_last);
          err_count++;
        end else begin
          exp_coef = coef_queue.pop_front();
          if (out_prod_index !== exp_coef.idx || out_prod_value !== exp_coef.val ||
              out_last !== exp_coef.last) begin
            if (err_count < 10)
              $display("mismatch: expected idx %0d value %h last %b, got idx %0d value %h last %b",
                       exp_coef.idx, exp_coef.val, exp_coef.last,
                       out_prod_index, out_prod_value, out_last);
            err_count++;
          end
        end
      end
    end
  end

  // driver: one request per transfer, random gap after each
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_count == in_issued) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          drv_item = req_queue.pop_front();
          in_command <= drv_item.cmd;
          in_coef_index <= drv_item.idx;
          in_coef_value <= drv_item.val;
          in_valid <= 1'b1;
          in_issued++;
          gap_left = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_ready) begin
        if (out_count != out_seen) begin
          out_seen = out_count;
          stall_left = draw_wait();
          if (stall_left != 0) out_ready <= 1'b0;
        end
      end else begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [COEF_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 15))
      0: return 6'd0;
      1: return 6'd32;
      2: return 6'd33;
      3: return 6'd63;
      4: return LEN_W'($urandom_range(0, 63));
      default: return LEN_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [COEF_W-1:0] val);
    req_t r;
    r.cmd = cmd;
    r.idx = idx;
    r.val = val;
    req_queue = {req_queue, r};
    if (cmd == CMD_WR_A) loaded_a[idx] = 1'b1;
    if (cmd == CMD_WR_B) loaded_b[idx] = 1'b1;
    if (cmd != CMD_NOP) stim_items++;
  endtask

  // fill never-written entries in range first so the compute reads defined data
  task automatic add_mul();
    for (int i = 0; i < gen_len_a; i++)
      if (!loaded_a[i]) add_item(CMD_WR_A, i[IDX_W-1:0], pick_value());
    for (int i = 0; i < gen_len_b; i++)
      if (!loaded_b[i]) add_item(CMD_WR_B, i[IDX_W-1:0], pick_value());
    add_item(CMD_MUL, IDX_W'($urandom()), $urandom());
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (req_queue.size() != 0 || in_count != in_issued || coef_queue.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_lengths(input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_LEN_A;
    cfg_wdata <= la;
    @(negedge clk);
    cfg_index <= CFG_LEN_B;
    cfg_wdata <= lb;
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_len_a = eff_len(la);
    gen_len_b = eff_len(lb);
  endtask

  task automatic random_phase(input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb);
    set_lengths(la, lb);
    no_stall = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: add_item(CMD_NOP, IDX_W'($urandom()), $urandom());
          1: add_item(($urandom_range(0, 1) == 0) ? CMD_WR_A : CMD_WR_B,
                      IDX_W'($urandom_range(0, 31)), pick_value());
          default: ;
        endcase
      end else begin
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 1) == 0)
            add_item(CMD_WR_A, IDX_W'($urandom_range(0, gen_len_a - 1)), pick_value());
          else
            add_item(CMD_WR_B, IDX_W'($urandom_range(0, gen_len_b - 1)), pick_value());
        end
      end
      add_mul();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: lengths at reset value, extreme operands
    add_item(CMD_WR_A, 5'd0, 32'h8000_0000);
    add_item(CMD_WR_B, 5'd0, 32'h8000_0000);
    add_mul();
    add_item(CMD_WR_A, 5'd0, 32'hffff_ffff);
    add_item(CMD_WR_B, 5'd0, 32'h7fff_ffff);
    add_item(CMD_MUL, 5'd31, 32'hffff_ffff);
    add_item(CMD_NOP, 5'd31, 32'hffff_ffff);
    add_item(CMD_WR_A, 5'd31, 32'h7fff_ffff);
    add_item(CMD_WR_B, 5'd31, 32'h8000_0000);
    add_mul();

    set_lengths(6'd2, 6'd3);
    add_item(CMD_WR_A, 5'd1, 32'h7fff_ffff);
    add_item(CMD_WR_B, 5'd1, 32'h8000_0000);
    add_item(CMD_WR_B, 5'd2, 32'hffff_ffff);
    add_mul();

    // zero length behaves as one
    set_lengths(6'd0, 6'd0);
    add_item(CMD_NOP, 5'd0, 32'h0000_0000);
    add_mul();

    stim_items = 0;
    random_phase(6'd32, 6'd32);
    random_phase(6'd63, 6'd33);
    random_phase(6'd1, 6'd32);
    random_phase(6'd32, 6'd0);
    while (stim_items < 220) random_phase(pick_len(), pick_len());

    wait_idle();
    repeat (40) @(negedge clk);
    if (coef_queue.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("PASS polynomial_multiplier");
    end else begin
      $display("FAIL polynomial_multiplier");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAIL polynomial_multiplier");
    $finish;
  end

endmodule
